// ----- rtl/core/smf_tep_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_tep_pkg
// Types and codes shared by the track event parser and its users.
// ----------------------------------------------------------------------------
package smf_tep_pkg;

  localparam int unsigned LenWidth = 28;

  typedef enum logic [1:0] {
    KIND_CHANNEL  = 2'd0,
    KIND_META     = 2'd1,
    KIND_SYSEX_F0 = 2'd2,
    KIND_SYSEX_F7 = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SHORT_BUF  = 3'd1,
    ERR_BAD_STATUS = 3'd2,
    ERR_LONG_LEN   = 3'd3,
    ERR_OVERRUN    = 3'd4
  } error_code_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] bytes_left;
  } in_item_t;

  typedef struct packed {
    logic                event_done;
    logic [1:0]          event_kind;
    logic [7:0]          status_value;
    logic [7:0]          first_data;
    logic [7:0]          second_data;
    logic [7:0]          payload_value;
    logic                payload_valid;
    logic [LenWidth-1:0] payload_length;
    logic                used_running;
    logic [2:0]          error_code;
  } out_item_t;

endpackage
`default_nettype wire

// ----- rtl/core/smf_track_event_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// smf_track_event_parser
// Standard MIDI file track event parser that takes one byte per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries one event byte and the count of bytes left in
// its buffer, and yields exactly one result transaction in the next cycle. The
// next-phase logic is combinational, so a byte can be taken every clock unless a
// result waits; the result register frees itself whenever out_ready is high.
module smf_track_event_parser
  import smf_tep_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_FIRST     = 3'd1,
    PH_SECOND    = 3'd2,
    PH_SECOND_RS = 3'd3,
    PH_META_TYPE = 3'd4,
    PH_LEN       = 3'd5,
    PH_PAYLOAD   = 3'd6
  } phase_t;

  localparam logic [3:0] NibbleProgChange = 4'hC;
  localparam logic [3:0] NibbleChanPress  = 4'hD;
  localparam logic [7:0] StatusMeta       = 8'hFF;
  localparam logic [7:0] StatusSysexF0    = 8'hF0;
  localparam logic [7:0] StatusSysexF7    = 8'hF7;
  localparam logic [15:0] MinLeft         = 16'd3;

  phase_t              phase_r, phase_nxt;
  logic [7:0]          running_r, running_nxt;
  logic [7:0]          cur_status_r, cur_status_nxt;
  logic [7:0]          held_first_r, held_first_nxt;
  logic [LenWidth-1:0] len_acc_r, len_acc_nxt;
  logic [2:0]          len_cnt_r, len_cnt_nxt;
  logic [LenWidth-1:0] remain_r, remain_nxt;
  logic                out_valid_r;
  out_item_t           out_data_r, out_data_nxt;

  logic                in_fire;
  logic [7:0]          b;
  logic [15:0]         left;
  logic                done;
  error_code_t         err;
  logic [7:0]          second;
  logic [7:0]          pval;
  logic                pvalid;
  logic                used;
  event_kind_t         kind;

  function automatic logic is_three_byte(input logic [7:0] status);
    is_three_byte = !((status[7:4] == NibbleProgChange) ||
                      (status[7:4] == NibbleChanPress));
  endfunction

  function automatic event_kind_t kind_of(input logic [7:0] status);
    if (status == StatusMeta) begin
      kind_of = KIND_META;
    end else if (status == StatusSysexF0) begin
      kind_of = KIND_SYSEX_F0;
    end else if (status == StatusSysexF7) begin
      kind_of = KIND_SYSEX_F7;
    end else begin
      kind_of = KIND_CHANNEL;
    end
  endfunction

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign b         = in_data.data_byte;
  assign left      = in_data.bytes_left;

  always_comb begin
    phase_nxt      = phase_r;
    running_nxt    = running_r;
    cur_status_nxt = cur_status_r;
    held_first_nxt = held_first_r;
    len_acc_nxt    = len_acc_r;
    len_cnt_nxt    = len_cnt_r;
    remain_nxt     = remain_r;
    done           = 1'b0;
    err            = ERR_NONE;
    second         = 8'd0;
    pval           = 8'd0;
    pvalid         = 1'b0;
    used           = 1'b0;

    case (phase_r)
      PH_FIRST: begin
        held_first_nxt = b;
        if (is_three_byte(cur_status_r)) begin
          phase_nxt = PH_SECOND;
        end else begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      PH_SECOND, PH_SECOND_RS: begin
        used      = (phase_r == PH_SECOND_RS);
        second    = b;
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end
      PH_META_TYPE: begin
        held_first_nxt = b;
        phase_nxt      = PH_LEN;
      end
      PH_LEN: begin
        len_acc_nxt = {len_acc_r[LenWidth-8:0], b[6:0]};
        len_cnt_nxt = len_cnt_r + 3'd1;
        if (b[7]) begin
          if (len_cnt_nxt[2]) begin
            err = ERR_LONG_LEN;
          end else if (left <= 16'd1) begin
            err = ERR_OVERRUN;
          end
        end else if (len_acc_nxt >= {{(LenWidth-16){1'b0}}, left}) begin
          err = ERR_OVERRUN;
        end else if (len_acc_nxt == '0) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end else begin
          remain_nxt = len_acc_nxt;
          phase_nxt  = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        pvalid     = 1'b1;
        pval       = b;
        remain_nxt = remain_r - LenWidth'(1);
        if (remain_nxt == '0) begin
          done      = 1'b1;
          phase_nxt = PH_IDLE;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (left < MinLeft) begin
          err = ERR_SHORT_BUF;
        end else begin
          held_first_nxt = 8'd0;
          len_acc_nxt    = '0;
          len_cnt_nxt    = 3'd0;
          remain_nxt     = '0;
          if (!b[7]) begin
            cur_status_nxt = running_r;
            if (running_r == 8'd0) begin
              err = ERR_BAD_STATUS;
            end else begin
              used           = 1'b1;
              held_first_nxt = b;
              if (is_three_byte(running_r)) begin
                phase_nxt = PH_SECOND_RS;
              end else begin
                done = 1'b1;
              end
            end
          end else if (b < StatusSysexF0) begin
            running_nxt    = b;
            cur_status_nxt = b;
            phase_nxt      = PH_FIRST;
          end else begin
            running_nxt    = 8'd0;
            cur_status_nxt = b;
            if (b == StatusMeta) begin
              phase_nxt = PH_META_TYPE;
            end else if ((b == StatusSysexF0) || (b == StatusSysexF7)) begin
              phase_nxt = PH_LEN;
            end else begin
              err = ERR_BAD_STATUS;
            end
          end
        end
      end
    endcase

    if (err != ERR_NONE) begin
      done      = 1'b1;
      phase_nxt = PH_IDLE;
    end

    kind = (err == ERR_SHORT_BUF) ? KIND_CHANNEL : kind_of(cur_status_nxt);

    out_data_nxt.event_done     = done;
    out_data_nxt.event_kind     = kind;
    out_data_nxt.status_value   = (err == ERR_SHORT_BUF) ? b : cur_status_nxt;
    out_data_nxt.first_data     = (err == ERR_SHORT_BUF) ? 8'd0 : held_first_nxt;
    out_data_nxt.second_data    = second;
    out_data_nxt.payload_value  = pval;
    out_data_nxt.payload_valid  = pvalid;
    out_data_nxt.payload_length = (kind != KIND_CHANNEL) ? len_acc_nxt : '0;
    out_data_nxt.used_running   = used;
    out_data_nxt.error_code     = err;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      running_r    <= 8'd0;
      cur_status_r <= 8'd0;
      held_first_r <= 8'd0;
      len_acc_r    <= '0;
      len_cnt_r    <= 3'd0;
      remain_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r      <= phase_nxt;
        running_r    <= running_nxt;
        cur_status_r <= cur_status_nxt;
        held_first_r <= held_first_nxt;
        len_acc_r    <= len_acc_nxt;
        len_cnt_r    <= len_cnt_nxt;
        remain_r     <= remain_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_err_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.error_code != ERR_NONE) |-> out_data_r.event_done)
    else $error("error result without event completion");

  a_payload_not_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.payload_valid |->
      (out_data_r.event_kind != KIND_CHANNEL) && (out_data_r.error_code == ERR_NONE))
    else $error("payload byte reported for a channel event or with an error");

  a_short_buffer: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (phase_r == PH_IDLE) && (left < MinLeft) |=>
      out_valid_r && (out_data_r.error_code == ERR_SHORT_BUF) && (phase_r == PH_IDLE))
    else $error("short buffer at event start not flagged");

  a_second_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.second_data != 8'd0) |-> out_data_r.event_done)
    else $error("second data byte reported before event completion");

endmodule
`default_nettype wire
